// File: sv/ldr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared types, constants and saturating arithmetic for the lens undistortion
// remap pipeline.
// ----------------------------------------------------------------------------
package ldr_pkg;

	localparam int QW         = 48;
	localparam int CW         = 20;
	localparam int PW         = 11;
	localparam int NUM_W      = 21;
	localparam int MAG_W      = 20;
	localparam int FRAC       = 16;
	localparam int DIV_W      = MAG_W + FRAC;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = DIV_W / DIV_STEP;
	localparam int LAT_DIV    = DIV_STAGES + 2;
	localparam int HALF_W     = QW / 2;

	typedef logic signed [QW-1:0] q_t;
	typedef logic [2:0]           reg_idx_t;

	localparam q_t Q_LIM  = {1'b0, {(QW-1){1'b1}}};
	localparam q_t Q_NLIM = -Q_LIM;
	localparam q_t Q_ONE  = q_t'(1) <<< FRAC;

	localparam reg_idx_t REG_FOCAL_X = 3'd0;
	localparam reg_idx_t REG_FOCAL_Y = 3'd1;
	localparam reg_idx_t REG_CENTRE_X = 3'd2;
	localparam reg_idx_t REG_CENTRE_Y = 3'd3;
	localparam reg_idx_t REG_RADIAL_1 = 3'd4;
	localparam reg_idx_t REG_RADIAL_2 = 3'd5;
	localparam reg_idx_t REG_TANG_1   = 3'd6;
	localparam reg_idx_t REG_TANG_2   = 3'd7;

	localparam logic [CW-1:0] RST_FOCAL    = 20'd256000;
	localparam logic [CW-1:0] RST_CENTRE_X = 20'd245760;
	localparam logic [CW-1:0] RST_CENTRE_Y = 20'd138240;

	function automatic q_t qadd(q_t a, q_t b);
		logic signed [QW:0] s;
		s = $signed({a[QW-1], a}) + $signed({b[QW-1], b});
		if (s > $signed({Q_LIM[QW-1], Q_LIM}))
			return Q_LIM;
		if (s < $signed({Q_NLIM[QW-1], Q_NLIM}))
			return Q_NLIM;
		return s[QW-1:0];
	endfunction

endpackage

// File: sv/ldr_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_qmul
// Three-stage saturating fixed-point multiplier: magnitudes, four half-width
// partial products, then sum, drop fraction bits, saturate and restore sign.
// ----------------------------------------------------------------------------
module ldr_qmul (
	input  logic          clk,
	input  logic          en,
	input  ldr_pkg::q_t   a,
	input  ldr_pkg::q_t   b,
	output ldr_pkg::q_t   p
);
	import ldr_pkg::*;

	logic [QW-1:0]       ma_s1, mb_s1;
	logic                neg_s1, neg_s2;
	logic [QW-1:0]       hh_s2, hl_s2, lh_s2, ll_s2;
	logic [2*QW-1:0]     full;
	logic [2*QW-FRAC-1:0] mag;
	logic [QW-2:0]       mag_sat;

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= a[QW-1] ? QW'(-a) : QW'(a);
			mb_s1  <= b[QW-1] ? QW'(-b) : QW'(b);
			neg_s1 <= a[QW-1] ^ b[QW-1];
			hh_s2  <= ma_s1[QW-1:HALF_W] * mb_s1[QW-1:HALF_W];
			hl_s2  <= ma_s1[QW-1:HALF_W] * mb_s1[HALF_W-1:0];
			lh_s2  <= ma_s1[HALF_W-1:0] * mb_s1[QW-1:HALF_W];
			ll_s2  <= ma_s1[HALF_W-1:0] * mb_s1[HALF_W-1:0];
			neg_s2 <= neg_s1;
			p      <= neg_s2 ? -q_t'({1'b0, mag_sat}) : q_t'({1'b0, mag_sat});
		end
	end

	always_comb begin
		full = {hh_s2, {QW{1'b0}}}
			+ ({{QW{1'b0}}, hl_s2} << HALF_W)
			+ ({{QW{1'b0}}, lh_s2} << HALF_W)
			+ {{QW{1'b0}}, ll_s2};
		mag = full[2*QW-1:FRAC];
		mag_sat = (|mag[2*QW-FRAC-1:QW-1]) ? Q_LIM[QW-2:0] : mag[QW-2:0];
	end

endmodule

// File: sv/ldr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_div
// Pipelined restoring divider: signed numerator shifted by the fraction
// width over an unsigned focal length, two quotient bits per stage,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ldr_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ldr_pkg::NUM_W-1:0]  num,
	input  logic [ldr_pkg::CW-1:0]            den,
	output ldr_pkg::q_t                       quo
);
	import ldr_pkg::*;

	logic [MAG_W-1:0] rem_q  [DIV_STAGES+1];
	logic [DIV_W-1:0] work_q [DIV_STAGES+1];
	logic             neg_q  [DIV_STAGES+1];
	logic [MAG_W-1:0] rem_n  [DIV_STAGES];
	logic [DIV_W-1:0] work_n [DIV_STAGES];
	logic [NUM_W-1:0] mag_in;

	assign mag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	always_comb begin
		logic [MAG_W:0]   cand;
		logic [MAG_W-1:0] r;
		logic [DIV_W-1:0] w;
		for (int k = 0; k < DIV_STAGES; k++) begin
			r = rem_q[k];
			w = work_q[k];
			for (int j = 0; j < DIV_STEP; j++) begin
				cand = {r, w[DIV_W-1]};
				w = w << 1;
				if (cand >= {1'b0, den}) begin
					cand = cand - {1'b0, den};
					w[0] = 1'b1;
				end
				r = cand[MAG_W-1:0];
			end
			rem_n[k] = r;
			work_n[k] = w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= '0;
			work_q[0] <= {mag_in[MAG_W-1:0], {FRAC{1'b0}}};
			neg_q[0]  <= num[NUM_W-1];
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_q[k+1]  <= rem_n[k];
				work_q[k+1] <= work_n[k];
				neg_q[k+1]  <= neg_q[k];
			end
			quo <= neg_q[DIV_STAGES] ? -q_t'({{(QW-DIV_W){1'b0}}, work_q[DIV_STAGES]})
				: q_t'({{(QW-DIV_W){1'b0}}, work_q[DIV_STAGES]});
		end
	end

endmodule

// File: sv/lens_undistortion_remap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_undistortion_remap_top
// Brown-Conrady coordinate remap: normalise, distort, map back to pixels.
// Datapath: the 18-stage divider, five three-stage multiplier ranks and
// their adder stages, then the frame check and output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// item is not taken. Reset clears valid bits and loads the default
// intrinsics (focal 1000.0, centre 960.0/540.0, zero coefficients).
// ----------------------------------------------------------------------------
module lens_undistortion_remap_top #(
	parameter int FRAME_WIDTH  = 1920,
	parameter int FRAME_HEIGHT = 1080
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [23:0]                s_tdata,   // out_col[10:0], out_row[21:11]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata,   // src_col[10:0], src_row[21:11]
	output logic [0:0]                 m_tuser,   // in_frame[0]
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  ldr_pkg::reg_idx_t          cfg_index,
	input  logic [ldr_pkg::CW-1:0]     cfg_data
);
	import ldr_pkg::*;

	localparam int LAT   = LAT_DIV + 22;
	localparam q_t COL_LIM = q_t'(FRAME_WIDTH * 256);
	localparam q_t ROW_LIM = q_t'(FRAME_HEIGHT * 256);

	logic [CW-1:0]        focal_x_q, focal_y_q, centre_x_q, centre_y_q;
	logic signed [CW-1:0] k1_q, k2_q, p1_q, p2_q;
	q_t fx, fy, cx, cy, k1, k2, p1, p2;

	logic                 en;
	logic [LAT-1:0]       vld_q;
	logic signed [NUM_W-1:0] num_x, num_y;

	q_t x1, y1, xx, yy, xy;
	q_t r2_s4, xy2_s4, xx2_s4, yy2_s4;
	q_t r2_s5, xy2_s5, tx_s5, ty_s5;
	q_t r4, k1r2, p1xy2, p2tx, p1ty, p2xy2;
	q_t tanx_s9, tany_s9, k2r4, sum_s12, rad_s13;
	q_t xr, yr, x2_s17, y2_s17, cm, rm, col_s21, row_s21;
	q_t x1d_q [13];
	q_t y1d_q [13];
	q_t tanxd_q [7];
	q_t tanyd_q [7];
	q_t k1d_q [3];

	logic [PW-1:0] src_col_q, src_row_q;
	logic          in_frame_q;
	logic          frame_hit;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= RST_FOCAL;
			focal_y_q  <= RST_FOCAL;
			centre_x_q <= RST_CENTRE_X;
			centre_y_q <= RST_CENTRE_Y;
			k1_q <= '0;
			k2_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FOCAL_X:  focal_x_q  <= cfg_data;
				REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				REG_CENTRE_X: centre_x_q <= cfg_data;
				REG_CENTRE_Y: centre_y_q <= cfg_data;
				REG_RADIAL_1: k1_q <= cfg_data;
				REG_RADIAL_2: k2_q <= cfg_data;
				REG_TANG_1:   p1_q <= cfg_data;
				REG_TANG_2:   p2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fx = q_t'({{(QW-CW){1'b0}}, focal_x_q});
	assign fy = q_t'({{(QW-CW){1'b0}}, focal_y_q});
	assign cx = q_t'({{(QW-CW){1'b0}}, centre_x_q});
	assign cy = q_t'({{(QW-CW){1'b0}}, centre_y_q});
	assign k1 = q_t'(k1_q);
	assign k2 = q_t'(k2_q);
	assign p1 = q_t'(p1_q);
	assign p2 = q_t'(p2_q);

	// pipeline control
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	// normalise
	assign num_x = $signed({2'b00, s_tdata[10:0], 8'h00}) - $signed({1'b0, centre_x_q});
	assign num_y = $signed({2'b00, s_tdata[21:11], 8'h00}) - $signed({1'b0, centre_y_q});

	ldr_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(focal_x_q), .quo(x1));
	ldr_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(focal_y_q), .quo(y1));

	// squares and cross term
	ldr_qmul u_mul_xx (.clk(clk), .en(en), .a(x1), .b(x1), .p(xx));
	ldr_qmul u_mul_yy (.clk(clk), .en(en), .a(y1), .b(y1), .p(yy));
	ldr_qmul u_mul_xy (.clk(clk), .en(en), .a(x1), .b(y1), .p(xy));

	// second rank
	ldr_qmul u_mul_r4   (.clk(clk), .en(en), .a(r2_s5), .b(r2_s5), .p(r4));
	ldr_qmul u_mul_k1   (.clk(clk), .en(en), .a(k1), .b(r2_s5), .p(k1r2));
	ldr_qmul u_mul_p1xy (.clk(clk), .en(en), .a(p1), .b(xy2_s5), .p(p1xy2));
	ldr_qmul u_mul_p2tx (.clk(clk), .en(en), .a(p2), .b(tx_s5), .p(p2tx));
	ldr_qmul u_mul_p1ty (.clk(clk), .en(en), .a(p1), .b(ty_s5), .p(p1ty));
	ldr_qmul u_mul_p2xy (.clk(clk), .en(en), .a(p2), .b(xy2_s5), .p(p2xy2));

	ldr_qmul u_mul_k2   (.clk(clk), .en(en), .a(k2), .b(r4), .p(k2r4));

	ldr_qmul u_mul_xr   (.clk(clk), .en(en), .a(x1d_q[12]), .b(rad_s13), .p(xr));
	ldr_qmul u_mul_yr   (.clk(clk), .en(en), .a(y1d_q[12]), .b(rad_s13), .p(yr));

	ldr_qmul u_mul_fx   (.clk(clk), .en(en), .a(fx), .b(x2_s17), .p(cm));
	ldr_qmul u_mul_fy   (.clk(clk), .en(en), .a(fy), .b(y2_s17), .p(rm));

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s4   <= qadd(xx, yy);
			xy2_s4  <= qadd(xy, xy);
			xx2_s4  <= qadd(xx, xx);
			yy2_s4  <= qadd(yy, yy);
			r2_s5   <= r2_s4;
			xy2_s5  <= xy2_s4;
			tx_s5   <= qadd(r2_s4, xx2_s4);
			ty_s5   <= qadd(r2_s4, yy2_s4);
			tanx_s9 <= qadd(p1xy2, p2tx);
			tany_s9 <= qadd(p1ty, p2xy2);
			sum_s12 <= qadd(k1d_q[2], k2r4);
			rad_s13 <= qadd(Q_ONE, sum_s12);
			x2_s17  <= qadd(xr, tanxd_q[6]);
			y2_s17  <= qadd(yr, tanyd_q[6]);
			col_s21 <= qadd(cm, cx);
			row_s21 <= qadd(rm, cy);
			x1d_q[0]   <= x1;
			y1d_q[0]   <= y1;
			tanxd_q[0] <= tanx_s9;
			tanyd_q[0] <= tany_s9;
			k1d_q[0]   <= k1r2;
			for (int i = 1; i < 13; i++) begin
				x1d_q[i] <= x1d_q[i-1];
				y1d_q[i] <= y1d_q[i-1];
			end
			for (int i = 1; i < 7; i++) begin
				tanxd_q[i] <= tanxd_q[i-1];
				tanyd_q[i] <= tanyd_q[i-1];
			end
			for (int i = 1; i < 3; i++)
				k1d_q[i] <= k1d_q[i-1];
		end
	end

	// frame check and output register
	assign frame_hit = (focal_x_q != '0) && (focal_y_q != '0)
		&& !col_s21[QW-1] && !row_s21[QW-1]
		&& (col_s21 < COL_LIM) && (row_s21 < ROW_LIM);

	always_ff @(posedge clk) begin
		if (en) begin
			in_frame_q <= frame_hit;
			src_col_q  <= frame_hit ? col_s21[PW+7:8] : '0;
			src_row_q  <= frame_hit ? row_s21[PW+7:8] : '0;
		end
	end

	assign m_tdata = {2'b00, src_row_q, src_col_q};
	assign m_tuser = in_frame_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[21:0] == '0)
		else $error("invalid item carries nonzero coordinates");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during a stall");

	a_zero_focal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (focal_x_q == '0 || focal_y_q == '0) |-> !m_tuser[0])
		else $error("item marked in frame with zero focal length");

endmodule
